// ===== sv/rotated_sorted_array_search_macros.svh =====
`ifndef ROTATED_SORTED_ARRAY_SEARCH_MACROS_SVH
`define ROTATED_SORTED_ARRAY_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RSAS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define RSAS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/rsas_pkg.sv =====
package rsas_pkg;

  localparam int DEPTH  = 1024;
  localparam int AW     = $clog2(DEPTH);
  localparam int IDX_W  = AW + 2;
  localparam int LEN_W  = 11;
  localparam int POS_W  = 10;
  localparam int VAL_W  = 32;
  localparam int FIDX_W = 10;
  localparam int CMP_W  = (LEN_W > IDX_W) ? LEN_W : IDX_W;

  localparam logic KIND_LOAD   = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RD_MID,
    ST_RD_LO,
    ST_RD_HI,
    ST_EVAL,
    ST_PL_RD,
    ST_PL_EVAL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic              found;
    logic [FIDX_W-1:0] found_index;
  } rsas_res_t;

endpackage

// ===== sv/rsas_if.sv =====
interface rsas_item_if import rsas_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    kind;
  logic [POS_W-1:0]        position;
  logic signed [VAL_W-1:0] value;

  modport source (output valid, kind, position, value, input ready);
  modport sink   (input valid, kind, position, value, output ready);
endinterface

interface rsas_res_if import rsas_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              found;
  logic [FIDX_W-1:0] found_index;

  modport source (output valid, found, found_index, input ready);
  modport sink   (input valid, found, found_index, output ready);
endinterface

interface rsas_cfg_if import rsas_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [LEN_W-1:0] used_length;

  modport source (output valid, used_length, input ready);
  modport sink   (input valid, used_length, output ready);
endinterface

// ===== sv/rotated_sorted_array_search.sv =====
// Channel | Dir | Payload                      | Transfer
// item_i  | in  | kind, position, value        | valid & ready
// res_o   | out | found, found_index           | valid & ready
// cfg_i   | in  | used_length                  | valid & ready (always ready)
//
// A load is accepted in the idle state and writes the element memory directly.
// A search is accepted in the idle state, then runs rotated probes (mid, first, last read in turn,
// then evaluated) and plain binary probes (read, then evaluated); an empty range ends a miss,
// and a done state hands over the result. The engine takes one search at a time.
// Reset clears control state and used_length; memory contents are not cleared.
// A result waits in the output register; a full register that is not being read stalls the engine.
module rotated_sorted_array_search import rsas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsas_item_if.sink  item_i,
  rsas_cfg_if.sink   cfg_i,
  rsas_res_if.source res_o
);

  `include "rotated_sorted_array_search_macros.svh"

  logic      eng_valid;
  logic      eng_ready;
  rsas_res_t eng_res;

  rsas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_i       (cfg_i),
    .res_valid_o (eng_valid),
    .res_o       (eng_res),
    .res_ready_i (eng_ready)
  );

  rsas_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eng_valid_i (eng_valid),
    .eng_res_i   (eng_res),
    .eng_ready_o (eng_ready),
    .res_o       (res_o)
  );

  `RSAS_ASSERT_NEXT(a_search_busy,
    item_i.valid && item_i.ready && (item_i.kind == KIND_SEARCH), !item_i.ready,
    "search accepted but input still ready")
  `RSAS_ASSERT_NEXT(a_load_no_busy,
    item_i.valid && item_i.ready && (item_i.kind == KIND_LOAD), item_i.ready,
    "load left engine busy")
  `RSAS_ASSERT_NOW(a_miss_zero_index,
    res_o.valid && !res_o.found, res_o.found_index == '0,
    "miss result with nonzero index")
  `RSAS_ASSERT_NOW(a_idle_no_result,
    item_i.ready, !eng_valid,
    "engine idle while presenting result")

endmodule

// ===== sv/rsas_ram.sv =====
module rsas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/rsas_ctrl.sv =====
module rsas_ctrl import rsas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsas_item_if.sink  item_i,
  rsas_cfg_if.sink   cfg_i,
  output logic       res_valid_o,
  output rsas_res_t  res_o,
  input  logic       res_ready_i
);

  state_e state_q, state_d;

  logic signed [IDX_W-1:0] lo_q, lo_d, hi_q, hi_d, mid;
  logic signed [VAL_W-1:0] key_q, key_d, m_q, m_d, a_q, a_d, rd_val;
  logic                    found_q, found_d;
  logic [FIDX_W-1:0]       fidx_q, fidx_d;
  logic [LEN_W-1:0]        used_length_q;

  logic             ram_we;
  logic [AW-1:0]    ram_raddr;
  logic [VAL_W-1:0] ram_rdata;

  logic [CMP_W-1:0] len_ext, n_eff;
  logic lo_le_hi, rot_hit, left_sorted, in_left, right_sorted, in_right;
  logic pl_hit, pl_lower, take_search;

  rsas_ram #(.WIDTH(VAL_W), .DEPTH(DEPTH)) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (AW'(item_i.position)),
    .wdata_i (item_i.value),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_length_q <= '0;
    end else if (cfg_i.valid) begin
      used_length_q <= cfg_i.used_length;
    end
  end

  assign len_ext = CMP_W'(used_length_q);
  assign n_eff   = (len_ext > CMP_W'(DEPTH)) ? CMP_W'(DEPTH) : len_ext;

  assign mid    = IDX_W'((lo_q + hi_q) >>> 1);
  assign rd_val = $signed(ram_rdata);

  assign lo_le_hi     = (lo_q <= hi_q);
  assign rot_hit      = (m_q == key_q);
  assign left_sorted  = (m_q >= a_q);
  assign in_left      = (key_q >= a_q) && (key_q < m_q);
  assign right_sorted = (m_q <= rd_val);
  assign in_right     = (key_q > m_q) && (key_q <= rd_val);
  assign pl_hit       = (rd_val == key_q);
  assign pl_lower     = (key_q < rd_val);
  assign take_search  = item_i.valid && (item_i.kind == KIND_SEARCH);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (take_search) state_d = ST_RD_MID;
      end
      ST_RD_MID: begin
        state_d = lo_le_hi ? ST_RD_LO : ST_DONE;
      end
      ST_RD_LO: state_d = ST_RD_HI;
      ST_RD_HI: state_d = ST_EVAL;
      ST_EVAL: begin
        if (rot_hit) begin
          state_d = ST_DONE;
        end else if (left_sorted) begin
          state_d = in_left ? ST_PL_RD : ST_RD_MID;
        end else if (right_sorted) begin
          state_d = in_right ? ST_PL_RD : ST_RD_MID;
        end else begin
          state_d = ST_DONE;
        end
      end
      ST_PL_RD: begin
        state_d = lo_le_hi ? ST_PL_EVAL : ST_DONE;
      end
      ST_PL_EVAL: begin
        state_d = pl_hit ? ST_DONE : ST_PL_RD;
      end
      ST_DONE: begin
        if (res_ready_i) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    item_i.ready = 1'b0;
    res_valid_o  = 1'b0;
    ram_we       = 1'b0;
    ram_raddr    = AW'(mid);
    case (state_q)
      ST_IDLE: begin
        item_i.ready = 1'b1;
        ram_we       = item_i.valid && (item_i.kind == KIND_LOAD) &&
                       (32'(item_i.position) < 32'(DEPTH));
      end
      ST_RD_LO: ram_raddr   = AW'(lo_q);
      ST_RD_HI: ram_raddr   = AW'(hi_q);
      ST_DONE:  res_valid_o = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    lo_d    = lo_q;
    hi_d    = hi_q;
    key_d   = key_q;
    m_d     = m_q;
    a_d     = a_q;
    found_d = found_q;
    fidx_d  = fidx_q;
    case (state_q)
      ST_IDLE: begin
        if (take_search) begin
          lo_d    = '0;
          hi_d    = IDX_W'(n_eff) - IDX_W'(1);
          key_d   = item_i.value;
          found_d = 1'b0;
          fidx_d  = '0;
        end
      end
      ST_RD_LO: m_d = rd_val;
      ST_RD_HI: a_d = rd_val;
      ST_EVAL: begin
        if (rot_hit) begin
          found_d = 1'b1;
          fidx_d  = FIDX_W'(mid);
        end else if (left_sorted) begin
          if (in_left) hi_d = mid - IDX_W'(1);
          else         lo_d = mid + IDX_W'(1);
        end else if (right_sorted) begin
          if (in_right) lo_d = mid;
          else          hi_d = mid - IDX_W'(1);
        end
      end
      ST_PL_EVAL: begin
        if (pl_hit) begin
          found_d = 1'b1;
          fidx_d  = FIDX_W'(mid);
        end else if (pl_lower) begin
          hi_d = mid - IDX_W'(1);
        end else begin
          lo_d = mid + IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    key_q   <= key_d;
    m_q     <= m_d;
    a_q     <= a_d;
    found_q <= found_d;
    fidx_q  <= fidx_d;
  end

  assign res_o.found       = found_q;
  assign res_o.found_index = fidx_q;

endmodule

// ===== sv/rsas_outreg.sv =====
module rsas_outreg import rsas_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       eng_valid_i,
  input  rsas_res_t  eng_res_i,
  output logic       eng_ready_o,
  rsas_res_if.source res_o
);

  logic      valid_q, valid_d;
  rsas_res_t res_q;
  logic      take;

  assign eng_ready_o = !valid_q || res_o.ready;
  assign take        = eng_valid_i && eng_ready_o;

  always_comb begin
    valid_d = valid_q;
    if (take) begin
      valid_d = 1'b1;
    end else if (res_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      res_q <= eng_res_i;
    end
  end

  assign res_o.valid       = valid_q;
  assign res_o.found       = res_q.found;
  assign res_o.found_index = res_q.found_index;

endmodule

// ===== sim/rsas_search_checker.sv =====
`timescale 1ns / 100ps

module rsas_search_checker import rsas_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  rsas_item_if item_mon,
  rsas_cfg_if  cfg_mon,
  rsas_res_if  res_mon,
  output int   fail_count_o,
  output int   pending_o
);

  logic signed [VAL_W-1:0] element_copy [DEPTH];
  logic [LEN_W-1:0]        length_copy;
  rsas_res_t               expected_answers [$];
  int                      mismatches;

  function automatic int bisect_sorted(input logic signed [VAL_W-1:0] key,
                                       input int lo, input int hi);
    int mid;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      if (element_copy[mid] == key) return mid;
      if (key < element_copy[mid]) hi = mid - 1;
      else lo = mid + 1;
    end
    return -1;
  endfunction

  function automatic rsas_res_t locate_key(input logic signed [VAL_W-1:0] key);
    int                      lo;
    int                      hi;
    int                      mid;
    int                      hit;
    logic signed [VAL_W-1:0] m;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    rsas_res_t               ans;
    lo  = 0;
    hi  = ((length_copy > DEPTH) ? DEPTH : int'(length_copy)) - 1;
    hit = -1;
    while (lo <= hi) begin
      mid = lo + (hi - lo) / 2;
      m   = element_copy[mid];
      a   = element_copy[lo];
      b   = element_copy[hi];
      if (m == key) begin
        hit = mid;
        break;
      end
      if (m >= a) begin
        if (key >= a && key < m) begin
          hit = bisect_sorted(key, lo, mid - 1);
          break;
        end
        lo = mid + 1;
      end else if (m <= b) begin
        if (key > m && key <= b) begin
          hit = bisect_sorted(key, mid, hi);
          break;
        end
        hi = mid - 1;
      end else begin
        break;
      end
    end
    ans.found       = (hit >= 0);
    ans.found_index = (hit >= 0) ? hit[FIDX_W-1:0] : '0;
    return ans;
  endfunction

  function automatic void note_mismatch(input rsas_res_t want, input logic got_found,
                                        input logic [FIDX_W-1:0] got_index);
    mismatches++;
    if (mismatches <= 10) begin
      $display("%0t: result mismatch: found %b index %0d, expected found %b index %0d",
               $realtime, got_found, got_index, want.found, want.found_index);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    rsas_res_t want;
    if (!rst_ni) begin
      expected_answers.delete();
      length_copy = '0;
      mismatches  = 0;
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (res_mon.valid && res_mon.ready) begin
        if (expected_answers.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("%0t: unexpected result: found %b index %0d", $realtime,
                     res_mon.found, res_mon.found_index);
          end
        end else begin
          want = expected_answers.pop_front();
          if (res_mon.found !== want.found || res_mon.found_index !== want.found_index) begin
            note_mismatch(want, res_mon.found, res_mon.found_index);
          end
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) length_copy = cfg_mon.used_length;
      if (item_mon.valid && item_mon.ready) begin
        if (item_mon.kind == KIND_LOAD) begin
          element_copy[item_mon.position] = item_mon.value;
        end else begin
          expected_answers.push_back(locate_key(item_mon.value));
        end
      end
      fail_count_o <= mismatches;
      pending_o    <= expected_answers.size();
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import rsas_pkg::*;

  localparam int                      SETTLE_CYCLES = 100;
  localparam int                      LONG_HOLD     = 400;
  localparam int                      ITEM_BUDGET   = 950;
  localparam logic signed [VAL_W-1:0] VAL_MIN       = 32'sh8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX       = 32'sh7fff_ffff;

  logic clk_i = 1'b0;
  logic rst_ni;

  int fail_count;
  int pending;
  int tx_idle_pct = 35;
  int rx_idle_pct = 62;
  int hold_reqs   = 0;
  int sent_count  = 0;
  bit bulk_fill   = 1'b0;

  logic signed [VAL_W-1:0] pattern    [DEPTH];
  logic signed [VAL_W-1:0] sorted_run [DEPTH];

  rsas_item_if item_if ();
  rsas_cfg_if  cfg_if ();
  rsas_res_if  res_if ();

  rotated_sorted_array_search u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .item_i (item_if),
    .cfg_i  (cfg_if),
    .res_o  (res_if)
  );

  rsas_search_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_mon     (item_if),
    .cfg_mon      (cfg_if),
    .res_mon      (res_if),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #10 clk_i = ~clk_i;

  task automatic send_item(input logic kind, input logic [POS_W-1:0] pos,
                           input logic signed [VAL_W-1:0] val);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    item_if.valid    <= 1'b1;
    item_if.kind     <= kind;
    item_if.position <= pos;
    item_if.value    <= val;
    do @(posedge clk_i); while (!item_if.ready);
    if (!bulk_fill) sent_count++;
  endtask

  task automatic load_element(input int pos, input logic signed [VAL_W-1:0] val);
    send_item(KIND_LOAD, pos[POS_W-1:0], val);
  endtask

  task automatic search_key(input logic signed [VAL_W-1:0] key);
    logic [POS_W-1:0] junk;
    junk = POS_W'($urandom_range(0, DEPTH - 1));
    send_item(KIND_SEARCH, junk, key);
  endtask

  task automatic wait_quiet();
    item_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_used_length(input int n);
    cfg_if.valid       <= 1'b1;
    cfg_if.used_length <= n[LEN_W-1:0];
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic make_pattern(input int n);
    longint step_max;
    longint span;
    longint acc;
    int     rot;
    int     shape;
    if (n > 0) begin
      shape = $urandom_range(99);
      if ($urandom_range(1)) step_max = 4;
      else step_max = 64'd4294967295 / n;
      span = 64'd4294967295 - step_max * n;
      acc  = -64'sd2147483648;
      if ($urandom_range(3) != 0) acc += $urandom_range(0, 32'(span));
      for (int i = 0; i < n; i++) begin
        sorted_run[i] = acc[31:0];
        acc += $urandom_range(1, 32'(step_max));
      end
      if ($urandom_range(3) == 0) sorted_run[n-1] = VAL_MAX;
      rot = $urandom_range(0, n - 1);
      for (int i = 0; i < n; i++) pattern[i] = sorted_run[(i + rot) % n];
      if (shape >= 80 && shape < 90) begin
        for (int i = 0; i < n; i++) pattern[i] = $urandom;
      end else if (shape >= 90 && shape < 95) begin
        for (int i = 0; i < n; i++) pattern[i] = $urandom_range(0, 3);
      end else if (shape >= 95) begin
        pattern[$urandom_range(0, n - 1)] = $urandom;
      end
    end
  endtask

  task automatic random_searches(input int n, input int count);
    int                      pick;
    logic signed [VAL_W-1:0] key;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(99);
      if (pick < 5) begin
        load_element($urandom_range(0, DEPTH - 1), $urandom);
      end
      pick = $urandom_range(99);
      if (n > 0 && pick < 60) begin
        key = pattern[$urandom_range(0, n - 1)];
      end else if (n > 0 && pick < 75) begin
        key = pattern[$urandom_range(0, n - 1)] + ($urandom_range(1) ? 1 : -1);
      end else if (pick < 85) begin
        case ($urandom_range(3))
          0: key = VAL_MIN;
          1: key = VAL_MAX;
          2: key = 0;
          default: key = -1;
        endcase
      end else begin
        key = $urandom;
      end
      search_key(key);
    end
  endtask

  initial begin : drain_results
    int hold_left;
    int hold_seen;
    hold_left    = 0;
    hold_seen    = 0;
    res_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_reqs != hold_seen) begin
        hold_seen = hold_reqs;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else begin
        res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : stimulus
    int n;
    int pick;
    rst_ni             = 1'b0;
    item_if.valid      = 1'b0;
    item_if.kind       = KIND_LOAD;
    item_if.position   = '0;
    item_if.value      = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.used_length = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    search_key(0);
    wait_quiet();
    set_used_length(1);
    load_element(0, VAL_MIN);
    search_key(VAL_MIN);
    search_key(VAL_MAX);
    wait_quiet();
    set_used_length(8);
    pattern[0] = 100;
    pattern[1] = 200;
    pattern[2] = VAL_MAX;
    pattern[3] = VAL_MIN;
    pattern[4] = -50;
    pattern[5] = 0;
    pattern[6] = 30;
    pattern[7] = 60;
    for (int i = 0; i < 8; i++) load_element(i, pattern[i]);
    search_key(VAL_MAX);
    search_key(VAL_MIN);
    search_key(60);
    search_key(100);
    search_key(45);
    load_element(3, -1000);
    load_element(7, -2000);
    search_key(5);
    wait_quiet();
    set_used_length(0);
    search_key(VAL_MAX);

    for (int p = 0; sent_count < ITEM_BUDGET; p++) begin
      if (sent_count < ITEM_BUDGET / 3) begin
        tx_idle_pct = 35;
        rx_idle_pct = 62;
      end else if (sent_count < 2 * ITEM_BUDGET / 3) begin
        tx_idle_pct = 62;
        rx_idle_pct = 35;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      wait_quiet();
      if (p == 3) begin
        set_used_length(int'({LEN_W{1'b1}}));
        make_pattern(DEPTH);
        bulk_fill = 1'b1;
        for (int i = 0; i < DEPTH; i++) load_element(i, pattern[i]);
        bulk_fill = 1'b0;
        random_searches(DEPTH, 30);
      end else if (p == 4) begin
        set_used_length(DEPTH);
        random_searches(DEPTH, 30);
      end else if (p == 5) begin
        n = $urandom_range(101, DEPTH - 1);
        set_used_length(n);
        random_searches(n, 30);
      end else begin
        pick = $urandom_range(99);
        if (pick < 5) n = 0;
        else if (pick < 15) n = $urandom_range(1, 3);
        else if (pick < 85) n = $urandom_range(4, 40);
        else n = $urandom_range(41, 100);
        set_used_length(n);
        make_pattern(n);
        for (int i = 0; i < n; i++) load_element(i, pattern[i]);
        if (p == 1) hold_reqs++;
        random_searches(n, (p == 1) ? 16 : $urandom_range(4, 20));
      end
    end
    wait_quiet();

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
